FILE: rtl/core/acp_pkg.sv
package acp_pkg;

   localparam int MAX_BLOCK  = 2048;
   localparam int ADDR_W     = $clog2(MAX_BLOCK);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int HALF_W     = ADDR_W;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int ENERGY_W   = 42;
   localparam int ACC_W      = 42;
   localparam int NUM_CELLS  = 8;
   localparam int CELL_IDX_W = $clog2(NUM_CELLS);
   localparam int RATE_W     = 18;
   localparam int LAG_W      = 10;
   localparam int LEVEL_W    = 15;
   localparam int DIV_W      = 42;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int DIVISOR_W  = CNT_W;
   localparam int ROOT_W     = DIV_W / 2;
   localparam int SQRT_TOP   = ((DIV_W - 1) / 2) * 2;

   localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(48000);
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = '1;
   localparam logic signed [ACC_W-1:0] BEST_INIT = -(ACC_W'(64'd1073741824));

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   typedef struct packed {
      logic shift;
      logic mul;
      logic accum;
      logic clear;
   } cell_ctl_type;

endpackage

FILE: rtl/core/acp_if.sv
interface acp_req_if import acp_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last;

   modport source (output valid, sample, last, input ready);
   modport sink (input valid, sample, last, output ready);
endinterface

interface acp_rsp_if import acp_pkg::*;;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level_rms;
   logic [RATE_W-1:0]  f0_hz;
   logic [LAG_W-1:0]   period_lag;
   logic               pitch_found;
   logic               block_overflow;

   modport source (output valid, level_rms, f0_hz, period_lag, pitch_found, block_overflow,
                   input ready);
   modport sink (input valid, level_rms, f0_hz, period_lag, pitch_found, block_overflow,
                 output ready);
endinterface

interface acp_csr_if import acp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/acp_cell.sv
module acp_cell import acp_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  sample_type   tap_in,
   input  sample_type   xi,
   output sample_type   tap_out,
   output acc_type      acc_out
);

   sample_type               tap_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   acc_type                  acc_ff;
   acc_type                  acc_in;

   assign prod_in = xi * tap_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.accum) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         tap_ff <= tap_in;
      end
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign tap_out = tap_ff;
   assign acc_out = acc_ff;

endmodule

FILE: rtl/core/acp_div.sv
module acp_div import acp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 busy,
   output logic                 done,
   output logic [DIV_W-1:0]     quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     dnd_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] dsr_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;

   assign trial = {rem_ff, dnd_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dnd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         dnd_ff <= {dnd_ff[DIV_W-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dnd_ff;

endmodule

FILE: rtl/core/acp_sqrt.sv
module acp_sqrt import acp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  value,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W-1:0] v_ff;
   logic [DIV_W-1:0] res_ff;
   logic [DIV_W-1:0] bit_ff;
   logic [DIV_W-1:0] sum;

   assign sum = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         res_ff <= '0;
         bit_ff <= DIV_W'(1) << SQRT_TOP;
      end else if (busy_ff) begin
         if (v_ff >= sum) begin
            v_ff   <= v_ff - sum;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

FILE: rtl/core/autocorrelation_pitch_level.sv
// autocorrelation pitch and level detector
// req_chan: one signed Q1.15 sample per item, last marks the end of a block.
// rsp_chan: one item per block with rms level, frequency, period lag, found
//   flag and overflow flag. csr_chan: sample rate in hertz, always ready.
// samples are taken one per cycle into a 2048-entry store; samples beyond
// that are dropped and flagged. after the last sample the input stalls
// while the block is worked out: a divide and a square root for the
// level, then the autocorrelation on a row of 8 mac cells, one group of
// 8 lags at a time, each lag summing h = count / 2 products, then, if a
// peak lag was found, a divide for the frequency.
// the cell row forms one product per cell per cycle while it runs.
// the result sits in an output register; the input reopens once it is
// loaded there, and a block that finishes while the receiver still stalls
// waits until the register is free.
// reset clears the block count, energy, held frequency and sample rate
// (48000); the sample store needs no clearing.
module autocorrelation_pitch_level import acp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   acp_req_if.sink       req_chan,
   acp_rsp_if.source     rsp_chan,
   acp_csr_if.sink       csr_chan
);

   localparam logic [3:0] ST_COLLECT = 4'd0;
   localparam logic [3:0] ST_LEVEL   = 4'd1;
   localparam logic [3:0] ST_LDIV    = 4'd2;
   localparam logic [3:0] ST_SQRT    = 4'd3;
   localparam logic [3:0] ST_CORR    = 4'd4;
   localparam logic [3:0] ST_RUN     = 4'd5;
   localparam logic [3:0] ST_DRAIN   = 4'd6;
   localparam logic [3:0] ST_SCAN    = 4'd7;
   localparam logic [3:0] ST_FREQ    = 4'd8;
   localparam logic [3:0] ST_FWAIT   = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [RATE_W-1:0]   held_ff, held_in;
   logic                ovf_ff, ovf_in;
   logic [RATE_W-1:0]   rate_ff;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [HALF_W-1:0]   base_ff, base_in;
   logic [HALF_W-1:0]   j_ff, j_in;
   logic [CELL_IDX_W-1:0] k_ff, k_in;
   logic                passed_ff, passed_in;
   acc_type             best_ff, best_in;
   logic [LAG_W-1:0]    peak_ff, peak_in;
   logic                found_ff, found_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]  out_level_ff, out_level_in;
   logic [RATE_W-1:0]   out_f0_ff, out_f0_in;
   logic [LAG_W-1:0]    out_lag_ff, out_lag_in;
   logic                out_found_ff, out_found_in;
   logic                out_ovf_ff, out_ovf_in;

   logic                shift_a_ff, mac_a_ff, mac_b_ff, mac_c_ff;
   logic                iss_shift, iss_mac, cell_clear;
   sample_type          rd_a_ff, rd_b_ff, xi_ff;
   sample_type          store_mem [MAX_BLOCK];
   logic [ADDR_W-1:0]   addr_a, addr_b;

   logic                req_acc;
   logic                full;
   logic signed [PROD_W-1:0] sq;
   logic [HALF_W-1:0]   half;
   logic [HALF_W-1:0]   lag_scan;
   acc_type             acc_sel;

   logic                div_start, div_busy, div_done;
   logic [DIV_W-1:0]    div_dividend, div_quot;
   logic [DIVISOR_W-1:0] div_divisor;
   logic                sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;
   logic [LEVEL_W-1:0]  level_sat;

   cell_ctl_type        cell_ctl;
   sample_type          cell_tap [NUM_CELLS];
   acc_type             cell_acc [NUM_CELLS];

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign full     = count_ff == CNT_W'(MAX_BLOCK);
   assign sq       = req_chan.sample * req_chan.sample;
   assign half     = count_ff[CNT_W-1:1];
   assign lag_scan = base_ff + HALF_W'(k_ff);
   assign acc_sel  = cell_acc[k_ff];
   assign addr_a   = ADDR_W'(j_ff - HALF_W'(NUM_CELLS - 1));
   assign addr_b   = ADDR_W'(base_ff + j_ff);
   assign level_sat = (|sqrt_root[ROOT_W-1:LEVEL_W]) ? LEVEL_MAX : sqrt_root[LEVEL_W-1:0];

   assign div_dividend = (state_ff == ST_LEVEL) ? DIV_W'(energy_ff) : DIV_W'(rate_ff);
   assign div_divisor  = (state_ff == ST_LEVEL) ? count_ff : DIVISOR_W'(peak_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      energy_in    = energy_ff;
      held_in      = held_ff;
      ovf_in       = ovf_ff;
      level_in     = level_ff;
      base_in      = base_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      passed_in    = passed_ff;
      best_in      = best_ff;
      peak_in      = peak_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      out_level_in = out_level_ff;
      out_f0_in    = out_f0_ff;
      out_lag_in   = out_lag_ff;
      out_found_in = out_found_ff;
      out_ovf_in   = out_ovf_ff;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      cell_clear   = 1'b0;
      iss_shift    = 1'b0;
      iss_mac      = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_COLLECT: begin
            if (req_acc) begin
               if (!full) begin
                  count_in  = count_ff + 1'b1;
                  energy_in = energy_ff + ENERGY_W'(sq[PROD_W-2:0]);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last) begin
                  state_in = ST_LEVEL;
               end
            end
         end
         ST_LEVEL: begin
            base_in   = HALF_W'(1);
            passed_in = 1'b0;
            best_in   = BEST_INIT;
            peak_in   = '0;
            found_in  = 1'b0;
            if (count_ff == '0) begin
               level_in = '0;
               state_in = ST_CORR;
            end else begin
               div_start = 1'b1;
               state_in  = ST_LDIV;
            end
         end
         ST_LDIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               level_in = level_sat;
               state_in = ST_CORR;
            end
         end
         ST_CORR: begin
            if (base_ff >= half) begin
               state_in = ST_FREQ;
            end else begin
               cell_clear = 1'b1;
               j_in       = '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            iss_shift = 1'b1;
            iss_mac   = j_ff >= HALF_W'(NUM_CELLS - 1);
            j_in      = j_ff + 1'b1;
            if (j_ff == half + HALF_W'(NUM_CELLS - 2)) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            k_in = k_ff + 1'b1;
            if (k_ff == CELL_IDX_W'(2)) begin
               k_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (lag_scan < half) begin
               if (!passed_ff) begin
                  if (acc_sel < 0) begin
                     passed_in = 1'b1;
                  end
               end else if (acc_sel > best_ff) begin
                  best_in = acc_sel;
                  peak_in = lag_scan[LAG_W-1:0];
               end
            end
            k_in = k_ff + 1'b1;
            if (k_ff == CELL_IDX_W'(NUM_CELLS - 1)) begin
               base_in  = base_ff + HALF_W'(NUM_CELLS);
               state_in = ST_CORR;
            end
         end
         ST_FREQ: begin
            if (peak_ff != '0) begin
               div_start = 1'b1;
               state_in  = ST_FWAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FWAIT: begin
            if (div_done) begin
               held_in  = div_quot[RATE_W-1:0];
               found_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_level_in = level_ff;
               out_f0_in    = held_ff;
               out_lag_in   = peak_ff;
               out_found_in = found_ff;
               out_ovf_in   = ovf_ff;
               count_in     = '0;
               energy_in    = '0;
               ovf_in       = 1'b0;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         energy_ff    <= '0;
         held_ff      <= '0;
         ovf_ff       <= 1'b0;
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
         shift_a_ff   <= 1'b0;
         mac_a_ff     <= 1'b0;
         mac_b_ff     <= 1'b0;
         mac_c_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         energy_ff    <= energy_in;
         held_ff      <= held_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_a_ff   <= iss_shift;
         mac_a_ff     <= iss_mac;
         mac_b_ff     <= mac_a_ff;
         mac_c_ff     <= mac_b_ff;
         if (csr_chan.valid && csr_chan.ready) begin
            rate_ff <= csr_chan.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      base_ff      <= base_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      passed_ff    <= passed_in;
      best_ff      <= best_in;
      peak_ff      <= peak_in;
      found_ff     <= found_in;
      out_level_ff <= out_level_in;
      out_f0_ff    <= out_f0_in;
      out_lag_ff   <= out_lag_in;
      out_found_ff <= out_found_in;
      out_ovf_ff   <= out_ovf_in;
      xi_ff        <= rd_a_ff;
   end

   // sample store
   always_ff @(posedge clock) begin
      if (req_acc && !full) begin
         store_mem[count_ff[ADDR_W-1:0]] <= req_chan.sample;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= store_mem[addr_a];
      rd_b_ff <= store_mem[addr_b];
   end

   // mac row
   assign cell_ctl.shift = shift_a_ff;
   assign cell_ctl.mul   = mac_b_ff;
   assign cell_ctl.accum = mac_c_ff;
   assign cell_ctl.clear = cell_clear;

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      sample_type tap_next;
      if (c == NUM_CELLS - 1) begin : g_top
         assign tap_next = rd_b_ff;
      end else begin : g_mid
         assign tap_next = cell_tap[c + 1];
      end
      acp_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .tap_in  (tap_next),
         .xi      (xi_ff),
         .tap_out (cell_tap[c]),
         .acc_out (cell_acc[c])
      );
   end

   acp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   acp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (div_quot),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign req_chan.ready = state_ff == ST_COLLECT;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.level_rms      = out_level_ff;
   assign rsp_chan.f0_hz          = out_f0_ff;
   assign rsp_chan.period_lag     = out_lag_ff;
   assign rsp_chan.pitch_found    = out_found_ff;
   assign rsp_chan.block_overflow = out_ovf_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCK))
      else $error("block count beyond store depth");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_found_lag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_found_ff |-> out_lag_ff != '0)
      else $error("pitch found without a lag");

   a_peak_below_half: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREQ) && (peak_ff != '0) |-> HALF_W'(peak_ff) < half)
      else $error("peak lag not below half block");

endmodule

FILE: bench/acp_tb_if.sv
// the interfaces are the RTL's own, in rtl/core/acp_if.sv
package acp_tb_types;
   import acp_pkg::*;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_rms;
      logic [RATE_W-1:0]  f0_hz;
      logic [LAG_W-1:0]   period_lag;
      logic               pitch_found;
      logic               block_overflow;
   } pitch_result_type;

   typedef struct packed {
      sample_type sample;
      logic       last;
   } sample_item_type;
endpackage

FILE: bench/testbench.sv
module testbench;
   import acp_pkg::*;
   import acp_tb_types::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   acp_req_if req_chan ();
   acp_rsp_if rsp_chan ();
   acp_csr_if csr_chan ();

   autocorrelation_pitch_level dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #2 clock = ~clock;

   sample_item_type  pending_samples[$];
   pitch_result_type expected_pitch[$];

   // predictor state
   int             block_samples[MAX_BLOCK];
   int             block_len;
   longint         block_energy;
   logic [RATE_W-1:0] held_f0;
   logic           dropped_seen;
   logic [RATE_W-1:0] rate_hz;

   int  mismatches;
   int  results_seen;
   int  blocks_sent;
   int  items_sent;
   longint cycle_count;
   bit  send_quiet;
   bit  recv_quiet;
   bit  csr_busy;

   function automatic longint root_floor(longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r = r + 1;
      return r;
   endfunction

   function automatic void predict_sample(sample_item_type it);
      pitch_result_type res;
      int half;
      int peak;
      longint best;
      longint acc;
      longint lvl;
      bit crossed;
      if (block_len < MAX_BLOCK) begin
         block_samples[block_len] = int'(it.sample);
         block_len++;
         block_energy += longint'(it.sample) * longint'(it.sample);
      end else begin
         dropped_seen = 1'b1;
      end
      if (!it.last) return;
      lvl = 0;
      if (block_len > 0) lvl = root_floor(block_energy / block_len);
      if (lvl > 32767) lvl = 32767;
      half = block_len / 2;
      peak = 0;
      best = -(64'sd1 <<< 30);
      crossed = 0;
      for (int lag = 1; lag < half; lag++) begin
         acc = 0;
         for (int i = 0; i < half; i++)
            acc += longint'(block_samples[i]) * longint'(block_samples[i + lag]);
         if (!crossed) begin
            if (acc < 0) crossed = 1;
         end else if (acc > best) begin
            best = acc;
            peak = lag;
         end
      end
      if (peak > 0) held_f0 = RATE_W'(rate_hz / peak);
      res.level_rms      = LEVEL_W'(lvl);
      res.f0_hz          = held_f0;
      res.period_lag     = LAG_W'(peak);
      res.pitch_found    = peak > 0;
      res.block_overflow = dropped_seen;
      expected_pitch.push_back(res);
      block_len    = 0;
      block_energy = 0;
      dropped_seen = 0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_sample('{req_chan.sample, req_chan.last});
            items_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_samples.size() > 0 && (send_quiet || $urandom_range(99) >= 26)) begin
               req_chan.valid  <= 1'b1;
               req_chan.sample <= pending_samples[0].sample;
               req_chan.last   <= pending_samples[0].last;
               void'(pending_samples.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pitch_result_type got;
      pitch_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.level_rms, rsp_chan.f0_hz, rsp_chan.period_lag,
                    rsp_chan.pitch_found, rsp_chan.block_overflow};
            results_seen++;
            if (expected_pitch.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = expected_pitch.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         rsp_chan.ready <= recv_quiet || $urandom_range(99) >= 26;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_sample(int value, bit last);
      sample_item_type it;
      it.sample = SAMPLE_W'(value);
      it.last   = last;
      pending_samples.push_back(it);
      if (last) blocks_sent++;
   endtask

   task automatic push_block(int len, int kind);
      int period;
      int amp;
      period = $urandom_range(2, 40);
      amp = $urandom_range(1, 32767);
      for (int i = 0; i < len; i++) begin
         case (kind)
            0: push_sample($urandom_range(0, 65535), i == len - 1);
            1: push_sample(((i % period) < period / 2) ? amp : -amp, i == len - 1);
            default: push_sample(((i % period) < period / 2) ? amp + $urandom_range(0, 200) - 100
                                 : -amp, i == len - 1);
         endcase
      end
   endtask

   task automatic drain_and_write(int rate);
      wait (results_seen == blocks_sent);
      repeat (200) @(posedge clock);
      csr_chan.data  <= RATE_W'(rate);
      csr_chan.valid <= 1'b1;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      rate_hz = RATE_W'(rate);
   endtask

   initial begin
      int sum;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      req_chan.last   = 1'b0;
      rsp_chan.ready  = 1'b0;
      csr_chan.valid  = 1'b0;
      csr_chan.data   = '0;
      block_len = 0; block_energy = 0; held_f0 = '0; dropped_seen = 0;
      rate_hz = RATE_RESET;
      mismatches = 0; results_seen = 0; blocks_sent = 0; items_sent = 0;
      cycle_count = 0; send_quiet = 0; recv_quiet = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-ish blocks, extremes, square wave
      push_sample(0, 1);
      push_sample(-32768, 1);
      push_sample(32767, 0); push_sample(-32768, 1);
      for (int i = 0; i < 8; i++) push_sample((i % 4 < 2) ? 32767 : -32768, i == 7);
      for (int i = 0; i < 12; i++) push_sample(0, i == 11);
      drain_and_write(0);
      for (int i = 0; i < 12; i++) push_sample((i % 4 < 2) ? 1000 : -1000, i == 11);
      drain_and_write(192000);

      // overflow block: two samples beyond the store, so the last one is dropped too
      for (int i = 0; i < MAX_BLOCK + 2; i++)
         push_sample((i % 16 < 8) ? 20000 : -20000, i == MAX_BLOCK + 1);
      drain_and_write(8000);

      // random phase with rate changes
      sum = 0;
      for (int phase = 0; phase < 3; phase++) begin
         for (int b = 0; b < 9; b++) begin
            int len;
            len = $urandom_range(1, 40);
            push_block(len, $urandom_range(0, 99) < 20 ? 0 : $urandom_range(1, 2));
            sum += len;
         end
         send_quiet = (phase == 1);
         recv_quiet = (phase == 1);
         drain_and_write(phase == 0 ? 262143 : $urandom_range(8000, 192000));
      end
      send_quiet = 0; recv_quiet = 0;
      while (sum < 650) begin
         int len;
         len = $urandom_range(1, 30);
         push_block(len, $urandom_range(0, 2));
         sum += len;
      end

      wait (results_seen == blocks_sent);
      repeat (500) @(posedge clock);
      $display("sent %0d samples in %0d blocks, checked %0d results, %0d mismatches",
               items_sent, blocks_sent, results_seen, mismatches);
      if (mismatches == 0 && expected_pitch.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

FILE: autocorrelation_pitch_level.f
rtl/core/acp_pkg.sv
rtl/core/acp_if.sv
rtl/core/acp_cell.sv
rtl/core/acp_div.sv
rtl/core/acp_sqrt.sv
rtl/core/autocorrelation_pitch_level.sv
bench/acp_tb_if.sv
bench/testbench.sv
